// ===== rtl/rgb_crossfade_timeout_core_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_crossfade_timeout_core_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef RGB_CROSSFADE_TIMEOUT_CORE_MACROS_SVH
`define RGB_CROSSFADE_TIMEOUT_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcf assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define RCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcf assertion failed");

`endif

// ===== rtl/rcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared widths, reset values, codes and types of the RGB cross-fade core.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int COLOR_W        = 8;
  localparam int CODE_W         = 8;
  localparam int FRAME_W        = 8;
  localparam int FADE_W         = 10;   // 4 * code
  localparam int CFG_W          = 14;
  localparam int ACC_W          = 18;   // holds 255 * 1020
  localparam int STEP_W         = $clog2(COLOR_W);
  localparam int TIMER_BITS_DEF = 14;

  localparam logic [CFG_W-1:0]  TIMEOUT_RESET = CFG_W'(10000);
  localparam logic [FADE_W-1:0] FADE_RESET    = FADE_W'(1000);
  localparam logic [FADE_W-1:0] POLL_RESET    = FADE_W'(100);

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_PACKET = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_DONE
  } seq_state_e;

  // per-cycle commands from the sequencer to the blend lanes
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic fin;
  } seq_ctl_t;

endpackage

// ===== rtl/rcf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_seq
// Sequencer: load, eight multiply steps, eight divide steps, hand-off.
// ----------------------------------------------------------------------------
module rcf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output rcf_pkg::seq_ctl_t ctl_o
);
  import rcf_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COLOR_W - 1);

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idle_o    = 1'b0;
    ctl_o     = '0;
    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) state_d = S_LOAD;
      end
      S_LOAD: begin
        ctl_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) state_d = S_DIV;
      end
      S_DIV: begin
        ctl_o.div = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) state_d = S_DONE;
      end
      S_DONE: begin
        ctl_o.fin = 1'b1;
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/rcf_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_lane
// One color channel: bit-serial old*(F-e) + tgt*e, then restoring divide by F.
// ----------------------------------------------------------------------------
module rcf_lane (
  input  logic                        clk_i,
  input  rcf_pkg::seq_ctl_t           ctl_i,
  input  logic [rcf_pkg::COLOR_W-1:0] old_i,
  input  logic [rcf_pkg::COLOR_W-1:0] tgt_i,
  input  logic [rcf_pkg::FADE_W-1:0]  fade_i,
  input  logic [rcf_pkg::FADE_W-1:0]  elapsed_i,
  output logic [rcf_pkg::COLOR_W-1:0] quo_o
);
  import rcf_pkg::*;

  logic [COLOR_W-1:0] old_sh_q, tgt_sh_q, quo_q;
  logic [ACC_W-1:0]   rem_w_q, el_w_q, acc_q, dsh_q;
  logic [ACC_W-1:0]   acc_d;
  logic               fits;

  assign fits = (acc_q >= dsh_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = '0;
    end else if (ctl_i.mul) begin
      acc_d = acc_q + (old_sh_q[0] ? rem_w_q : '0) + (tgt_sh_q[0] ? el_w_q : '0);
    end else if (ctl_i.div && fits) begin
      acc_d = acc_q - dsh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.load) begin
      old_sh_q <= old_i;
      tgt_sh_q <= tgt_i;
      rem_w_q  <= ACC_W'(fade_i - elapsed_i);
      el_w_q   <= ACC_W'(elapsed_i);
      dsh_q    <= ACC_W'(fade_i) << (COLOR_W - 1);
    end else if (ctl_i.mul) begin
      old_sh_q <= old_sh_q >> 1;
      tgt_sh_q <= tgt_sh_q >> 1;
      rem_w_q  <= rem_w_q << 1;
      el_w_q   <= el_w_q << 1;
    end else if (ctl_i.div) begin
      quo_q <= {quo_q[COLOR_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/rgb_crossfade_timeout_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_crossfade_timeout_core
// Linear RGB cross-fade driven by millisecond ticks and color packets.
// ----------------------------------------------------------------------------
// Each input beat is a tick or a color packet and yields one output beat with
// the blended color and the poll-due flag. The state is updated on the cycle
// a beat is accepted; the three channels are then blended in parallel lanes,
// each running an eight-step bit-serial multiply and an eight-step restoring
// divide. The next beat is taken only after the load, multiply, divide and
// hand-off steps are done and the sequencer is back in idle; the hand-off
// waits while the output register is still full. The blackout timeout
// register may be written while no item is in flight.
module rgb_crossfade_timeout_core #(
  parameter int TIMER_BITS = rcf_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rcf_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [rcf_pkg::COLOR_W-1:0] red_in_i,
  input  logic [rcf_pkg::COLOR_W-1:0] green_in_i,
  input  logic [rcf_pkg::COLOR_W-1:0] blue_in_i,
  input  logic [rcf_pkg::CODE_W-1:0]  poll_code_i,
  input  logic [rcf_pkg::CODE_W-1:0]  fade_code_i,
  input  logic [rcf_pkg::FRAME_W-1:0] frame_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rcf_pkg::COLOR_W-1:0] red_out_o,
  output logic [rcf_pkg::COLOR_W-1:0] green_out_o,
  output logic [rcf_pkg::COLOR_W-1:0] blue_out_o,
  output logic                        poll_due_o
);
  import rcf_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int NCH   = 3;

  logic [CFG_W-1:0]      timeout_q;
  logic [COLOR_W-1:0]    old_q [NCH];
  logic [COLOR_W-1:0]    tgt_q [NCH];
  logic [COLOR_W-1:0]    old_d [NCH];
  logic [COLOR_W-1:0]    tgt_d [NCH];
  logic [COLOR_W-1:0]    pkt_color [NCH];
  logic [COLOR_W-1:0]    quo [NCH];
  logic [COLOR_W-1:0]    out_q [NCH];
  logic [FRAME_W-1:0]    last_frame_q, last_frame_d;
  logic [FADE_W-1:0]     fade_q, fade_d, poll_q, poll_d;
  logic [TIMER_BITS-1:0] fade_el_q, fade_el_d, idle_q, idle_d, since_q, since_d;
  logic [TIMER_BITS-1:0] idle_upd;
  logic                  out_valid_q, poll_due_q;

  logic     in_fire, is_packet, new_frame, blackout, bypass;
  logic     seq_idle, out_free, out_load;
  seq_ctl_t ctl;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = seq_idle;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_packet   = (opcode_e'(opcode_i) == OP_PACKET);
  assign new_frame   = is_packet && (frame_number_i != last_frame_q);
  assign pkt_color   = '{red_in_i, green_in_i, blue_in_i};

  // tick or packet first, then the blackout check on the updated idle time
  always_comb begin
    last_frame_d = last_frame_q;
    fade_d       = fade_q;
    poll_d       = poll_q;
    fade_el_d    = fade_el_q;
    since_d      = since_q;
    idle_upd     = idle_q;
    old_d        = old_q;
    tgt_d        = tgt_q;
    if (!is_packet) begin
      fade_el_d = sat_inc(fade_el_q);
      since_d   = sat_inc(since_q);
      idle_upd  = sat_inc(idle_q);
    end else begin
      idle_upd = '0;
      if (new_frame) begin
        last_frame_d = frame_number_i;
        old_d        = tgt_q;
        tgt_d        = pkt_color;
        poll_d       = {poll_code_i, 2'b00};
        fade_d       = {fade_code_i, 2'b00};
        fade_el_d    = '0;
        since_d      = '0;
      end
    end
    blackout = (CMP_W'(idle_upd) > CMP_W'(timeout_q));
    idle_d   = idle_upd;
    if (blackout) begin
      old_d     = tgt_d;
      tgt_d     = '{default: '0};
      idle_d    = '0;
      fade_el_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RESET;
      old_q        <= '{default: '0};
      tgt_q        <= '{default: '0};
      last_frame_q <= '0;
      fade_q       <= FADE_RESET;
      poll_q       <= POLL_RESET;
      fade_el_q    <= '0;
      idle_q       <= '0;
      since_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
      if (in_fire) begin
        old_q        <= old_d;
        tgt_q        <= tgt_d;
        last_frame_q <= last_frame_d;
        fade_q       <= fade_d;
        poll_q       <= poll_d;
        fade_el_q    <= fade_el_d;
        idle_q       <= idle_d;
        since_q      <= since_d;
      end
    end
  end

  rcf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .out_free_i (out_free),
    .idle_o     (seq_idle),
    .ctl_o      (ctl)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    rcf_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .old_i     (old_q[c]),
      .tgt_i     (tgt_q[c]),
      .fade_i    (fade_q),
      .elapsed_i (fade_el_q[FADE_W-1:0]),
      .quo_o     (quo[c])
    );
  end

  // the state holds still while the lanes run, so it can be read at hand-off
  assign bypass   = (fade_q == '0) || (fade_el_q >= TIMER_BITS'(fade_q));
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ctl.fin && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < NCH; c++) out_q[c] <= bypass ? tgt_q[c] : quo[c];
      poll_due_q <= (since_q > TIMER_BITS'(poll_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
  assign poll_due_o  = poll_due_q;

endmodule

// ===== rtl/rcf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks on the cross-fade core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_crossfade_timeout_core_macros.svh"

module rcf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rcf_pkg::COLOR_W-1:0] red_out_o,
  input logic                        cfg_ready_o
);

  // a stalled result beat keeps its data
  `RCF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o))
  // one item at a time: busy right after an input beat
  `RCF_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)
  // a result never shows up the cycle after its input beat
  `RCF_ASSERT_NEXT(a_no_instant, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)
  // a new result only comes from an item in flight
  `RCF_ASSERT_NOW(a_rise_busy, $rose(out_valid_o), !$past(in_ready_o))
  `RCF_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready_o)

endmodule

bind rgb_crossfade_timeout_core rcf_checker u_rcf_checker (.*);

// ===== tb/sv/tb_rgb_crossfade_timeout_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_crossfade_timeout_core
// Self-checking bench for the RGB cross-fade core with blackout timeout.
// ----------------------------------------------------------------------------
// Drives tick and color-packet beats through the valid/ready input port and
// models the fader state in the bench: old/goal colors, frame tracking, fade
// and poll lengths, and the saturating elapsed counters. Every output beat is
// checked field by field against the oldest predicted beat. Covers power-on
// values, a long idle stretch under the reset timeout, instant and long fades,
// repeated frames, timeout edge values, random traffic over several timeout
// settings, and a long idle run at the largest timeout.
// ----------------------------------------------------------------------------
module tb_rgb_crossfade_timeout_core;
  import rcf_pkg::*;

  localparam int TMR_W = TIMER_BITS_DEF;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               poll;
  } shade_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic                 opcode_i       = OP_TICK;
  logic [COLOR_W-1:0]   red_in_i       = '0;
  logic [COLOR_W-1:0]   green_in_i     = '0;
  logic [COLOR_W-1:0]   blue_in_i      = '0;
  logic [CODE_W-1:0]    poll_code_i    = '0;
  logic [CODE_W-1:0]    fade_code_i    = '0;
  logic [FRAME_W-1:0]   frame_number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [COLOR_W-1:0]   red_out_o;
  logic [COLOR_W-1:0]   green_out_o;
  logic [COLOR_W-1:0]   blue_out_o;
  logic                 poll_due_o;

  rgb_crossfade_timeout_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .poll_code_i    (poll_code_i),
    .fade_code_i    (fade_code_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .poll_due_o     (poll_due_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // fader model state
  logic [CFG_W-1:0]   blackout_limit;
  logic [COLOR_W-1:0] prev_rgb [3];
  logic [COLOR_W-1:0] goal_rgb [3];
  logic [FRAME_W-1:0] seen_frame;
  logic [FADE_W-1:0]  fade_len;
  logic [FADE_W-1:0]  poll_len;
  logic [TMR_W-1:0]   fade_age;
  logic [TMR_W-1:0]   idle_age;
  logic [TMR_W-1:0]   frame_age;

  shade_t shade_q [$];
  int     mismatches = 0;
  bit     gaps_on    = 1'b0;
  bit     stalls_on  = 1'b0;
  int     ready_hold = 0;

  function automatic logic [TMR_W-1:0] bump(logic [TMR_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic shade_t next_shade(opcode_e op, logic [COLOR_W-1:0] pr,
                                        logic [COLOR_W-1:0] pg, logic [COLOR_W-1:0] pb,
                                        logic [CODE_W-1:0] pc, logic [CODE_W-1:0] fc,
                                        logic [FRAME_W-1:0] fr);
    shade_t             s;
    logic [COLOR_W-1:0] pkt [3];
    logic [COLOR_W-1:0] mix [3];
    int unsigned        f;
    int unsigned        e;
    pkt[0] = pr;
    pkt[1] = pg;
    pkt[2] = pb;
    if (op == OP_TICK) begin
      fade_age  = bump(fade_age);
      idle_age  = bump(idle_age);
      frame_age = bump(frame_age);
    end else begin
      idle_age = '0;
      if (fr != seen_frame) begin
        seen_frame = fr;
        for (int i = 0; i < 3; i++) begin
          prev_rgb[i] = goal_rgb[i];
          goal_rgb[i] = pkt[i];
        end
        poll_len  = {pc, 2'b00};
        fade_len  = {fc, 2'b00};
        fade_age  = '0;
        frame_age = '0;
      end
    end
    // blackout: current goal becomes the start point, fade length kept
    if (idle_age > blackout_limit) begin
      for (int i = 0; i < 3; i++) begin
        prev_rgb[i] = goal_rgb[i];
        goal_rgb[i] = '0;
      end
      idle_age = '0;
      fade_age = '0;
    end
    f = 32'(fade_len);
    e = 32'(fade_age);
    for (int i = 0; i < 3; i++) begin
      if (f == 0 || e >= f) mix[i] = goal_rgb[i];
      else mix[i] = COLOR_W'((prev_rgb[i] * (f - e) + goal_rgb[i] * e) / f);
    end
    s.red   = mix[0];
    s.green = mix[1];
    s.blue  = mix[2];
    s.poll  = (frame_age > poll_len);
    return s;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < 30) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // output side: random stall bursts on out_ready_i
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    shade_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shade_q.size() == 0) begin
        note_mismatch("output beat with nothing expected");
      end else begin
        want = shade_q.pop_front();
        if (red_out_o !== want.red)
          note_mismatch($sformatf("red %0d, want %0d", red_out_o, want.red));
        if (green_out_o !== want.green)
          note_mismatch($sformatf("green %0d, want %0d", green_out_o, want.green));
        if (blue_out_o !== want.blue)
          note_mismatch($sformatf("blue %0d, want %0d", blue_out_o, want.blue));
        if (poll_due_o !== want.poll)
          note_mismatch($sformatf("poll_due %0b, want %0b", poll_due_o, want.poll));
      end
    end
  end

  task automatic send_item(opcode_e op, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                           logic [COLOR_W-1:0] b, logic [CODE_W-1:0] pc,
                           logic [CODE_W-1:0] fc, logic [FRAME_W-1:0] fr);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    red_in_i       <= r;
    green_in_i     <= g;
    blue_in_i      <= b;
    poll_code_i    <= pc;
    fade_code_i    <= fc;
    frame_number_i <= fr;
    do @(posedge clk_i); while (!in_ready_o);
    shade_q.push_back(next_shade(op, r, g, b, pc, fc, fr));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // tick with junk in the ignored fields
  task automatic tick(int n = 1);
    repeat (n)
      send_item(OP_TICK, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                CODE_W'($urandom), CODE_W'($urandom), FRAME_W'($urandom));
  endtask

  task automatic packet(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b,
                        logic [CODE_W-1:0] pc, logic [CODE_W-1:0] fc,
                        logic [FRAME_W-1:0] fr);
    send_item(OP_PACKET, r, g, b, pc, fc, fr);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    blackout_limit = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // frame 0 right after reset is a repeat; poll flag trips after 100 ms
  task automatic test_power_on();
    packet(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    tick(102);
    packet(8'h12, 8'h34, 8'h56, 8'h01, 8'h01, 8'h00);
    tick(2);
    wait_drained();
  endtask

  // reset timeout holds over a long idle stretch, no register write before it
  task automatic test_reset_timeout();
    packet(8'd200, 8'd100, 8'd50, 8'd3, 8'd5, 8'd1);
    tick(120);
    wait_drained();
  endtask

  task automatic test_fades();
    write_timeout(CFG_W'(20));
    packet(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'd7);   // instant fade
    tick(2);
    packet(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'd8);
    tick(5);
    packet(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'd9);   // longest fade
    tick(3);
    packet(8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'd9);   // repeat: fade continues
    tick(2);
    packet(8'h80, 8'h7F, 8'h01, 8'h02, 8'h02, 8'd0);   // frame 0 now new
    tick(2);
    wait_drained();
  endtask

  task automatic test_timeout_edges();
    write_timeout('0);                                  // fires after one tick
    packet(8'd100, 8'd150, 8'd200, 8'd1, 8'd3, 8'd1);
    tick(3);
    wait_drained();
    write_timeout(CFG_W'(1));
    packet(8'd10, 8'd250, 8'd90, 8'd2, 8'd2, 8'd2);
    tick(4);
    wait_drained();
    write_timeout(CFG_W'(2));                           // blackout mid-fade
    packet(8'hFF, 8'hC0, 8'h3C, 8'd0, 8'hFF, 8'd3);
    tick(5);
    wait_drained();
  endtask

  task automatic run_random(int n);
    logic [FRAME_W-1:0] fr;
    logic [CODE_W-1:0]  fc;
    logic [COLOR_W-1:0] c [3];
    int                 pick;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) begin
        tick();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) fr = seen_frame + FRAME_W'($urandom_range(1, 255));
        else if (pick < 85) fr = seen_frame;
        else fr = FRAME_W'($urandom);
        fc = ($urandom_range(0, 9) < 7) ? CODE_W'($urandom_range(0, 12)) : CODE_W'($urandom);
        for (int i = 0; i < 3; i++) begin
          pick = $urandom_range(0, 9);
          c[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end
        packet(c[0], c[1], c[2],
               ($urandom_range(0, 1) != 0) ? CODE_W'($urandom_range(0, 8)) : CODE_W'($urandom),
               fc, fr);
      end
    end
    wait_drained();
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] limits [5];
    limits[0] = '0;
    limits[1] = CFG_W'(1);
    limits[2] = CFG_W'($urandom_range(2, 40));
    limits[3] = CFG_W'($urandom_range(41, 600));
    limits[4] = CFG_W'(16000);
    foreach (limits[k]) begin
      write_timeout(limits[k]);
      run_random(260);
    end
  endtask

  // largest timeout never fires over a long idle run
  task automatic test_saturation();
    write_timeout('1);
    packet(8'hA5, 8'h5A, 8'hC3, 8'hFF, 8'h10, seen_frame + 1'b1);
    tick(200);
    wait_drained();
  endtask

  initial begin
    blackout_limit = TIMEOUT_RESET;
    seen_frame     = '0;
    fade_len       = FADE_RESET;
    poll_len       = POLL_RESET;
    fade_age       = '0;
    idle_age       = '0;
    frame_age      = '0;
    for (int i = 0; i < 3; i++) begin
      prev_rgb[i] = '0;
      goal_rgb[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on();
    test_reset_timeout();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_fades();
    test_timeout_edges();
    test_random();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_saturation();

    repeat (25) @(posedge clk_i);
    if (shade_q.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", shade_q.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
